FILE: sv/vn_pkg.sv
// Shared types and constants for the 4-vector normaliser.
// Used by the square-root cell, the divider cell and the top level.
package vn_pkg;

  localparam int COMP_W = 24;               // component width, signed
  localparam int SUM_W  = 49;               // exact sum of four squares
  localparam int N_W    = 50;               // sum padded to whole bit pairs
  localparam int LEN_W  = 25;               // floor root of the sum
  localparam int REM_W  = 28;               // root remainder
  localparam int SQRT_STEPS = N_W / 2;

  typedef struct packed {
    logic [3:0][COMP_W-1:0] comp;
    logic                   above;          // sum not below threshold
  } vn_item_t;

  typedef struct packed {
    logic [N_W-1:0]   n;
    logic [LEN_W-1:0] q;
    logic [REM_W-1:0] r;
    vn_item_t         item;
  } vn_sq_t;

endpackage

FILE: sv/vn_sqrt_cell.sv
// One root digit of the floor square root: takes the top bit pair of n.
// Depends on vn_pkg.
module vn_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           valid_in,
  input  vn_pkg::vn_sq_t d_in,
  output logic           valid_out,
  output vn_pkg::vn_sq_t d_out
);

  logic [vn_pkg::REM_W-1:0] rr;
  logic [vn_pkg::REM_W-1:0] t;
  logic                     ge;
  vn_pkg::vn_sq_t           d_next;

  always_comb begin
    rr = {d_in.r[vn_pkg::REM_W-3:0], d_in.n[vn_pkg::N_W-1 -: 2]};
    t  = {1'b0, d_in.q, 2'b01};
    ge = rr >= t;
    d_next      = d_in;
    d_next.n    = {d_in.n[vn_pkg::N_W-3:0], 2'b00};
    d_next.r    = ge ? rr - t : rr;
    d_next.q    = {d_in.q[vn_pkg::LEN_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

FILE: sv/vn_div_cell.sv
// One quotient bit for all four components, restoring long division.
// Depends on vn_pkg.
module vn_div_cell #(
  parameter int QW = 17
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     valid_in,
  input  logic [vn_pkg::LEN_W-1:0] len_in,
  input  logic [3:0][vn_pkg::LEN_W-1:0] r_in,
  input  logic [3:0][QW-1:0]       q_in,
  input  logic [3:0][QW-1:0]       b_in,   // dividend bits still to bring down
  input  vn_pkg::vn_item_t         item_in,
  output logic                     valid_out,
  output logic [vn_pkg::LEN_W-1:0] len_out,
  output logic [3:0][vn_pkg::LEN_W-1:0] r_out,
  output logic [3:0][QW-1:0]       q_out,
  output logic [3:0][QW-1:0]       b_out,
  output vn_pkg::vn_item_t         item_out
);

  logic [3:0][vn_pkg::LEN_W:0]   rr;
  logic [3:0]                    ge;
  logic [3:0][vn_pkg::LEN_W-1:0] r_next;
  logic [3:0][QW-1:0]            q_next;
  logic [3:0][QW-1:0]            b_next;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rr[i] = {r_in[i], b_in[i][QW-1]};
      ge[i] = rr[i] >= {1'b0, len_in};
      r_next[i] = ge[i] ? vn_pkg::LEN_W'(rr[i] - {1'b0, len_in})
                        : rr[i][vn_pkg::LEN_W-1:0];
      q_next[i] = {q_in[i][QW-2:0], ge[i]};
      b_next[i] = {b_in[i][QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
    if (en) begin
      len_out  <= len_in;
      r_out    <= r_next;
      q_out    <= q_next;
      b_out    <= b_next;
      item_out <= item_in;
    end
  end

endmodule

FILE: sv/vector4_normalize_top.sv
// Top level of the 4-vector normaliser: squares, sqrt chain, divider chain.
// Depends on vn_pkg, vn_sqrt_cell and vn_div_cell.
//
// Input beats on s_axis carry the four Q8.16 components; each gives exactly
// one beat on m_axis with the four result components, the floor length and
// the normalised flag in tuser.
// The squares are registered, then the sum and threshold compare; then
// come one cell per root bit in the square-root chain and one cell per
// quotient bit in the divider chain. A new beat is taken every cycle
// while the output is not stalled.
// The whole pipeline advances together; when the output beat is held by a
// stalled receiver, every stage holds and s_axis_tready drops. Once the
// receiver takes the beat, flow resumes with no bubble.
// cfg_we writes min_norm_squared (reset value 1); write it only while idle.
// Reset empties the pipeline; no clearing pass is needed.
module vector4_normalize_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // in_x, in_y, in_z, in_w
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // out_x, out_y, out_z, out_w, length, zero pad
  output logic         m_axis_tuser,   // was_normalized
  input  logic         cfg_we,
  input  logic [48:0]  cfg_wdata
);

  localparam int QW = FRAC_BITS + 1;
  localparam int CW = vn_pkg::COMP_W;
  localparam int LW = vn_pkg::LEN_W;
  localparam int SQ = vn_pkg::SQRT_STEPS;

  logic [vn_pkg::SUM_W-1:0] min_norm_squared;
  logic                     en;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_norm_squared <= vn_pkg::SUM_W'(1);
    end else if (cfg_we) begin
      min_norm_squared <= cfg_wdata;
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // squares
  logic [3:0][CW-1:0]   in_mag;
  logic [3:0][2*CW-1:0] sq;
  logic [3:0][CW-1:0]   comp_a;
  logic                 valid_a;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_mag[i] = s_axis_tdata[i*CW+CW-1] ? CW'(-s_axis_tdata[i*CW +: CW])
                                          : s_axis_tdata[i*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (en) begin
      valid_a <= s_axis_tvalid;
    end
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq[i]     <= in_mag[i] * in_mag[i];
        comp_a[i] <= s_axis_tdata[i*CW +: CW];
      end
    end
  end

  // sum and threshold
  logic [vn_pkg::SUM_W-1:0] sum_a;
  vn_pkg::vn_sq_t           sq_d   [SQ+1];
  logic                     sq_v   [SQ+1];

  assign sum_a = vn_pkg::SUM_W'({1'b0, sq[0]}) + vn_pkg::SUM_W'({1'b0, sq[1]})
               + vn_pkg::SUM_W'({1'b0, sq[2]}) + vn_pkg::SUM_W'({1'b0, sq[3]});

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= valid_a;
    end
    if (en) begin
      sq_d[0].n          <= {1'b0, sum_a};
      sq_d[0].q          <= '0;
      sq_d[0].r          <= '0;
      sq_d[0].item.comp  <= comp_a;
      sq_d[0].item.above <= sum_a >= min_norm_squared;
    end
  end

  for (genvar s = 0; s < SQ; s++) begin : g_sqrt
    vn_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (sq_v[s]),
      .d_in     (sq_d[s]),
      .valid_out(sq_v[s+1]),
      .d_out    (sq_d[s+1])
    );
  end

  // divider chain; the quotient never exceeds 2^FRAC_BITS
  logic                     dv_v    [QW+1];
  logic [LW-1:0]            dv_len  [QW+1];
  logic [3:0][LW-1:0]       dv_r    [QW+1];
  logic [3:0][QW-1:0]       dv_q    [QW+1];
  logic [3:0][QW-1:0]       dv_b    [QW+1];
  vn_pkg::vn_item_t         dv_item [QW+1];
  logic [3:0][CW-1:0]       dmag;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dmag[i] = sq_d[SQ].item.comp[i][CW-1] ? CW'(-sq_d[SQ].item.comp[i])
                                            : sq_d[SQ].item.comp[i];
      dv_r[0][i] = LW'(dmag[i] >> 1);
      dv_q[0][i] = '0;
      dv_b[0][i] = {dmag[i][0], {(QW-1){1'b0}}};
    end
  end

  assign dv_v[0]    = sq_v[SQ];
  assign dv_len[0]  = sq_d[SQ].q;
  assign dv_item[0] = sq_d[SQ].item;

  for (genvar s = 0; s < QW; s++) begin : g_div
    vn_div_cell #(.QW(QW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (dv_v[s]),
      .len_in   (dv_len[s]),
      .r_in     (dv_r[s]),
      .q_in     (dv_q[s]),
      .b_in     (dv_b[s]),
      .item_in  (dv_item[s]),
      .valid_out(dv_v[s+1]),
      .len_out  (dv_len[s+1]),
      .r_out    (dv_r[s+1]),
      .q_out    (dv_q[s+1]),
      .b_out    (dv_b[s+1]),
      .item_out (dv_item[s+1])
    );
  end

  // result select
  logic               do_norm;
  logic [3:0][CW-1:0] res;

  assign do_norm = dv_item[QW].above && (dv_len[QW] != '0);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (!do_norm) begin
        res[i] = dv_item[QW].comp[i];
      end else if (dv_item[QW].comp[i][CW-1]) begin
        res[i] = CW'(-{{(CW-QW){1'b0}}, dv_q[QW][i]});
      end else begin
        res[i] = CW'({{(CW-QW){1'b0}}, dv_q[QW][i]});
      end
    end
  end

  assign m_axis_tvalid = dv_v[QW];
  assign m_axis_tdata  = {7'd0, dv_len[QW], res[3], res[2], res[1], res[0]};
  assign m_axis_tuser  = do_norm;

endmodule

FILE: dv/vector4_normalize_top_tb.sv
// Self-checking bench for vector4_normalize_top: directed table, then random beats.
// Depends on vn_pkg and the vector4_normalize_top RTL; predicts each result in-line.
module vector4_normalize_top_tb;

  typedef struct packed {
    logic [3:0][vn_pkg::COMP_W-1:0] comp;
    logic [vn_pkg::LEN_W-1:0]       len;
    logic                           norm;
  } vec_result_t;

  typedef struct {
    logic [3:0][vn_pkg::COMP_W-1:0] comp;
    logic                           known;   // expected result typed in below
    vec_result_t                    res;
  } vec_row_t;

  localparam int FRAC = 16;
  localparam int LATENCY = 2 + vn_pkg::SQRT_STEPS + FRAC + 1;
  localparam int WATCHDOG = 20000;
  localparam logic [23:0] MAXP = 24'h7fffff;
  localparam logic [23:0] MAXN = 24'h800000;
  localparam logic [23:0] ONE  = 24'h010000;

  logic         clk, rst;
  logic         s_axis_tvalid, s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_we;
  logic [48:0]  cfg_wdata;

  vector4_normalize_top uut (.*);

  logic [48:0]  min_norm_sq;
  vec_result_t  pending_results[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  bit           long_hold = 0;
  bit           rx_free = 1;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic vec_result_t normalise(logic [3:0][vn_pkg::COMP_W-1:0] c);
    vec_result_t r;
    logic [63:0] sum, len, mag, q;
    logic signed [63:0] v;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      v = 64'(signed'(c[i]));
      mag = v < 0 ? -v : v;
      sum += mag * mag;
    end
    len = floor_root(sum);
    r.len = len[vn_pkg::LEN_W-1:0];
    if (sum < 64'(min_norm_sq) || len == 0) begin
      r.comp = c;
      r.norm = 0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        v = 64'(signed'(c[i]));
        mag = v < 0 ? -v : v;
        q = (mag << FRAC) / len;
        if (v < 0) q = -q;
        r.comp[i] = q[23:0];
      end
      r.norm = 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // output side: random stalls, plus one long hold-off to back the pipe up
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_axis_tready <= 0;
        repeat (150) @(posedge clk);
        long_hold = 0;
      end
      if (!rx_free && $urandom_range(0, 3) == 0)
        m_axis_tready <= 0;
      else if ($urandom_range(0, 30) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(5, 40)) @(posedge clk);
        m_axis_tready <= 1;
      end else
        m_axis_tready <= 1;
    end
  end

  always @(posedge clk) begin
    vec_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0)
        report_mismatch("unexpected beat", m_axis_tdata[63:0], 0);
      else begin
        want = pending_results.pop_front();
        for (int i = 0; i < 4; i++)
          if (m_axis_tdata[24*i +: 24] !== want.comp[i])
            report_mismatch($sformatf("component %0d", i), m_axis_tdata[24*i +: 24],
                            want.comp[i]);
        if (m_axis_tdata[120:96] !== want.len)
          report_mismatch("length", m_axis_tdata[120:96], want.len);
        if (m_axis_tuser !== want.norm)
          report_mismatch("normalised flag", m_axis_tuser, want.norm);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("vector4_normalize_top verification failed");
      $finish;
    end
  end

  task automatic send_vector(logic [3:0][vn_pkg::COMP_W-1:0] c, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3))
        @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= c;
    pending_results.push_back(normalise(c));
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic set_threshold(logic [48:0] value);
    s_axis_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we    <= 1;
    cfg_wdata <= value;
    min_norm_sq = value;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [23:0] rand_comp(int style);
    case (style)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 2 * 65536)) - 65536);
      2: return 24'($signed($urandom_range(0, 64)) - 32);
      default: return $urandom_range(0, 1) ? 24'(MAXP - $urandom_range(0, 255))
                                             : 24'(MAXN + $urandom_range(0, 255));
    endcase
  endfunction

  vec_row_t table_rows[$];

  initial begin
    vec_row_t row;
    vec_result_t want, got;
    logic [48:0] thresholds[5];
    logic [3:0][vn_pkg::COMP_W-1:0] c;
    int style;

    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    min_norm_sq = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed rows; known rows carry a hand-typed result
    row.known = 1;
    row.comp = '{0, 0, 0, 0};
    row.res = '{comp: '{0, 0, 0, 0}, len: 0, norm: 0};
    table_rows.push_back(row);
    row.comp = '{0, 0, 0, ONE};
    row.res = '{comp: '{0, 0, 0, ONE}, len: 25'h10000, norm: 1};
    table_rows.push_back(row);
    row.comp = '{0, 0, 0, -ONE};
    row.res = '{comp: '{0, 0, 0, -ONE}, len: 25'h10000, norm: 1};
    table_rows.push_back(row);
    row.comp = '{0, 0, 0, 24'd1};
    row.res = '{comp: '{0, 0, 0, ONE}, len: 1, norm: 1};
    table_rows.push_back(row);
    row.comp = '{MAXN, MAXN, MAXN, MAXN};
    row.res = '{comp: '{-(ONE / 2), -(ONE / 2), -(ONE / 2), -(ONE / 2)},
                len: 25'h1000000, norm: 1};
    table_rows.push_back(row);
    row.known = 0;
    foreach (row.comp[i]) row.comp[i] = 0;
    for (int k = 0; k < 4; k++) begin
      row.comp = '{0, 0, 0, 0};
      row.comp[k] = MAXP;
      table_rows.push_back(row);
      row.comp[k] = MAXN;
      table_rows.push_back(row);
    end
    row.comp = '{MAXP, MAXP, MAXP, MAXP}; table_rows.push_back(row);
    row.comp = '{MAXP, MAXN, 24'd1, -24'd1}; table_rows.push_back(row);
    row.comp = '{ONE, ONE, ONE, ONE}; table_rows.push_back(row);
    row.comp = '{24'd3, -24'd4, 0, 0}; table_rows.push_back(row);
    row.comp = '{24'h555555, 24'haaaaaa, 24'h123456, 24'hfedcba}; table_rows.push_back(row);

    foreach (table_rows[r]) begin
      if (table_rows[r].known) begin
        want = table_rows[r].res;
        got = normalise(table_rows[r].comp);
        if (got !== want)
          report_mismatch($sformatf("table row %0d predictor", r), got.len, want.len);
      end
      send_vector(table_rows[r].comp, 0);
    end

    // zero threshold: all-zero vector must still pass through untouched
    set_threshold(0);
    send_vector('{0, 0, 0, 0}, 0);
    send_vector('{0, 0, 24'd2, 0}, 0);

    thresholds = '{49'h1_0000_0000, 49'h1_0000_0000_0000, 49'h0_0400_0000,
                   49'h0_0001_0000, 1};
    for (int p = 0; p < 5; p++) begin
      set_threshold(p == 1 ? 49'h1_0000_0000_0000 : thresholds[p]);
      if (p == 2) begin
        long_hold = 1;
      end
      for (int n = 0; n < 260; n++) begin
        style = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) c[i] = rand_comp(style);
        send_vector(c, p != 3);
      end
    end
    // the largest register value too
    set_threshold(49'h1_ffff_ffff_ffff);
    for (int n = 0; n < 40; n++) begin
      for (int i = 0; i < 4; i++) c[i] = rand_comp(3);
      send_vector(c, 1);
    end

    s_axis_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (mismatches == 0)
      $display("vector4_normalize_top verification clean");
    else
      $display("vector4_normalize_top verification failed");
    $finish;
  end
endmodule
